@@ sv/bpd_pkg.sv @@
// package for the button press duration block: payload structs, codes and constants
// no dependencies; used by button_press_duration_fsm_unit
package bpd_pkg;

  // item modes
  typedef enum logic [1:0] {
    MODE_SAMPLE      = 2'd0,
    MODE_CONSUME     = 2'd1,
    MODE_CLEAR       = 2'd2,
    MODE_FORCE_CLEAR = 2'd3
  } mode_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_PRESS    = 3'd0,
    REG_MAX_PRESS    = 3'd1,
    REG_EXT_PRESS    = 3'd2,
    REG_INIT_PERIOD  = 3'd3,
    REG_CLEAR_PERIOD = 3'd4
  } cfg_reg_t;

  // button phase, one-hot
  typedef enum logic [8:0] {
    ST_INIT         = 9'b000000001,
    ST_READY_CLEAR  = 9'b000000010,
    ST_UNPRESSED    = 9'b000000100,
    ST_RECENT       = 9'b000001000,
    ST_REGISTERED   = 9'b000010000,
    ST_TRANSITIONAL = 9'b000100000,
    ST_EXTENDED     = 9'b001000000,
    ST_EXT_INVALID  = 9'b010000000,
    ST_CONSUMED     = 9'b100000000
  } phase_t;

  // numeric state codes seen on the result
  localparam logic [3:0] CODE_INIT         = 4'd0;
  localparam logic [3:0] CODE_READY_CLEAR  = 4'd1;
  localparam logic [3:0] CODE_UNPRESSED    = 4'd2;
  localparam logic [3:0] CODE_RECENT       = 4'd3;
  localparam logic [3:0] CODE_REGISTERED   = 4'd4;
  localparam logic [3:0] CODE_TRANSITIONAL = 4'd5;
  localparam logic [3:0] CODE_EXTENDED     = 4'd6;
  localparam logic [3:0] CODE_EXT_INVALID  = 4'd7;
  localparam logic [3:0] CODE_CONSUMED     = 4'd8;

  // configuration reset values
  localparam logic [15:0] MIN_PRESS_RST    = 16'd750;
  localparam logic [15:0] MAX_PRESS_RST    = 16'd3000;
  localparam logic [15:0] EXT_PRESS_RST    = 16'd5000;
  localparam logic [15:0] INIT_PERIOD_RST  = 16'd1000;
  localparam logic [15:0] CLEAR_PERIOD_RST = 16'd1000;

  // timing constants
  localparam logic [31:0] EXT_INVALID_EXTRA_MS = 32'd2000;
  localparam logic [31:0] FIRST_WINDOW_MS      = 32'd10000;

  // divide by 100: drop two bits, then multiply by ceil(2^35 / 25) and shift by 35;
  // exact for every 30-bit dividend
  localparam int          DIV_PRE_SHIFT = 2;
  localparam int          DIV_RECIP_W   = 31;
  localparam int          DIV_SHIFT     = 35;
  localparam int          DIV_PROD_W    = 32 - DIV_PRE_SHIFT + DIV_RECIP_W;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 31'd1374389535;

  // input item
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic        pressed_raw;
  } item_t;

  // result item
  typedef struct packed {
    logic [3:0] state_code;
    logic       press_registered;
    logic       press_extended;
    logic       press_in_progress;
    logic       press_consumed;
    logic       ready_to_work;
    logic       clear_accepted;
    logic       in_first_window;
    logic [7:0] since_press_tenths;
    logic [7:0] since_clear_tenths;
  } result_t;

endpackage

@@ sv/button_press_duration_fsm_unit.sv @@
// top level of the button press duration block: state update, tenths divide, result register
// depends on bpd_pkg
//
// Button press duration tracker. Every item transfer (sample, mark consumed, clear request,
// forced clear) updates the button phase and time stamps in the cycle it is taken, so one
// item can be taken every clock while item_ready is high. After the transfer, the stage
// register holds the updated phase and the two elapsed-time differences; the next stage
// turns the differences into tenths of a second with a reciprocal multiply and loads the
// result register. Items keep flowing while a result waits, until both stages are full.
// The configuration port is always ready; registers should only be written while idle.
module button_press_duration_fsm_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bpd_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bpd_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  typedef struct packed {
    bpd_pkg::phase_t phase;
    logic            accepted;
    logic            first_window;
    logic [31:0]     press_diff;
    logic [31:0]     clear_diff;
  } stage_t;

  // configuration registers
  logic [15:0] min_press_ms;
  logic [15:0] max_press_ms;
  logic [15:0] ext_press_ms;
  logic [15:0] init_period_ms;
  logic [15:0] clear_period_ms;

  // button state
  bpd_pkg::phase_t phase, phase_next;
  logic [31:0]     press_start_time, press_start_next;
  logic [31:0]     init_start_time, init_start_next;
  logic            init_started, init_started_next;
  logic [31:0]     last_clear_time, last_clear_next;
  logic            first_window, first_window_next;
  logic            clear_ok;

  // elapsed times against the stored stamps
  logic [31:0] since_init;
  logic [31:0] held;
  logic [31:0] since_clear;

  // pipeline
  logic   item_xfer;
  logic   stage_en;
  logic   out_en;
  logic   stage_valid;
  stage_t stage;
  stage_t stage_next;
  logic [bpd_pkg::DIV_PROD_W-1:0] press_prod;
  logic [bpd_pkg::DIV_PROD_W-1:0] clear_prod;
  bpd_pkg::result_t result_next;

  assign cfg_ready  = 1'b1;
  assign out_en     = !result_valid || result_ready;
  assign stage_en   = !stage_valid || out_en;
  assign item_ready = stage_en;
  assign item_xfer  = item_valid && item_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_press_ms    <= bpd_pkg::MIN_PRESS_RST;
      max_press_ms    <= bpd_pkg::MAX_PRESS_RST;
      ext_press_ms    <= bpd_pkg::EXT_PRESS_RST;
      init_period_ms  <= bpd_pkg::INIT_PERIOD_RST;
      clear_period_ms <= bpd_pkg::CLEAR_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpd_pkg::REG_MIN_PRESS:    min_press_ms    <= cfg_data;
        bpd_pkg::REG_MAX_PRESS:    max_press_ms    <= cfg_data;
        bpd_pkg::REG_EXT_PRESS:    ext_press_ms    <= cfg_data;
        bpd_pkg::REG_INIT_PERIOD:  init_period_ms  <= cfg_data;
        bpd_pkg::REG_CLEAR_PERIOD: clear_period_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // next button state for the item on the input
  always_comb begin
    phase_next        = phase;
    press_start_next  = press_start_time;
    init_start_next   = init_start_time;
    init_started_next = init_started;
    last_clear_next   = last_clear_time;
    first_window_next = first_window;
    clear_ok          = 1'b0;
    since_init        = item.now_ms - init_start_time;
    held              = item.now_ms - press_start_time;
    since_clear       = item.now_ms - last_clear_time;

    unique case (item.mode) inside
      bpd_pkg::MODE_SAMPLE: begin
        if (first_window && (item.now_ms > bpd_pkg::FIRST_WINDOW_MS)) begin
          first_window_next = 1'b0;
        end
        unique case (phase)
          bpd_pkg::ST_INIT: begin
            if (!init_started) begin
              init_started_next = 1'b1;
              init_start_next   = item.now_ms;
            end else if (since_init > {16'd0, init_period_ms}) begin
              phase_next = bpd_pkg::ST_READY_CLEAR;
            end
          end
          bpd_pkg::ST_READY_CLEAR: begin
          end
          bpd_pkg::ST_UNPRESSED: begin
            if (item.pressed_raw) begin
              phase_next       = bpd_pkg::ST_RECENT;
              press_start_next = item.now_ms;
            end
          end
          bpd_pkg::ST_RECENT: begin
            if (!item.pressed_raw) begin
              phase_next = bpd_pkg::ST_UNPRESSED;
            end else if (held >= {16'd0, min_press_ms}) begin
              phase_next = bpd_pkg::ST_REGISTERED;
            end
          end
          bpd_pkg::ST_REGISTERED: begin
            if (!item.pressed_raw) begin
              phase_next = bpd_pkg::ST_UNPRESSED;
            end else if (held >= {16'd0, max_press_ms}) begin
              phase_next = bpd_pkg::ST_TRANSITIONAL;
            end
          end
          bpd_pkg::ST_TRANSITIONAL: begin
            if (!item.pressed_raw) begin
              phase_next = bpd_pkg::ST_UNPRESSED;
            end else if (held >= {16'd0, ext_press_ms}) begin
              phase_next = bpd_pkg::ST_EXTENDED;
            end
          end
          bpd_pkg::ST_EXTENDED: begin
            if (!item.pressed_raw) begin
              phase_next = bpd_pkg::ST_UNPRESSED;
            end else if (held >= ({16'd0, ext_press_ms} + bpd_pkg::EXT_INVALID_EXTRA_MS)) begin
              phase_next = bpd_pkg::ST_EXT_INVALID;
            end
          end
          bpd_pkg::ST_EXT_INVALID, bpd_pkg::ST_CONSUMED: begin
            if (!item.pressed_raw) begin
              phase_next = bpd_pkg::ST_UNPRESSED;
            end
          end
          default: begin
          end
        endcase
      end
      bpd_pkg::MODE_CONSUME: begin
        phase_next = bpd_pkg::ST_CONSUMED;
      end
      bpd_pkg::MODE_CLEAR, bpd_pkg::MODE_FORCE_CLEAR: begin
        // forced clear and ready-to-clear always clear; unpressed only once the clear period has run
        clear_ok = (item.mode == bpd_pkg::MODE_FORCE_CLEAR) ||
                   (phase == bpd_pkg::ST_READY_CLEAR) ||
                   ((phase == bpd_pkg::ST_UNPRESSED) &&
                    (since_clear >= {16'd0, clear_period_ms}));
        if (clear_ok) begin
          last_clear_next = item.now_ms;
          if (phase == bpd_pkg::ST_READY_CLEAR) begin
            phase_next = bpd_pkg::ST_UNPRESSED;
          end
        end
      end
      default: begin
      end
    endcase

    // differences are taken against the stamps after the update
    stage_next.phase        = phase_next;
    stage_next.accepted     = clear_ok;
    stage_next.first_window = first_window_next;
    stage_next.press_diff   = item.now_ms - press_start_next;
    stage_next.clear_diff   = item.now_ms - last_clear_next;
  end

  // button state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= bpd_pkg::ST_INIT;
      press_start_time <= 32'd0;
      init_start_time  <= 32'd0;
      init_started     <= 1'b0;
      last_clear_time  <= 32'd0;
      first_window     <= 1'b1;
    end else if (item_xfer) begin
      phase            <= phase_next;
      press_start_time <= press_start_next;
      init_start_time  <= init_start_next;
      init_started     <= init_started_next;
      last_clear_time  <= last_clear_next;
      first_window     <= first_window_next;
    end
  end

  // first stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_en) begin
      stage_valid <= item_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      stage <= stage_next;
    end
  end

  // tenths of a second by reciprocal multiply
  assign press_prod = bpd_pkg::DIV_PROD_W'(stage.press_diff[31:bpd_pkg::DIV_PRE_SHIFT]) *
                      bpd_pkg::DIV_PROD_W'(bpd_pkg::DIV_RECIP);
  assign clear_prod = bpd_pkg::DIV_PROD_W'(stage.clear_diff[31:bpd_pkg::DIV_PRE_SHIFT]) *
                      bpd_pkg::DIV_PROD_W'(bpd_pkg::DIV_RECIP);

  // result fields from the updated phase
  always_comb begin
    unique case (stage.phase)
      bpd_pkg::ST_INIT:         result_next.state_code = bpd_pkg::CODE_INIT;
      bpd_pkg::ST_READY_CLEAR:  result_next.state_code = bpd_pkg::CODE_READY_CLEAR;
      bpd_pkg::ST_UNPRESSED:    result_next.state_code = bpd_pkg::CODE_UNPRESSED;
      bpd_pkg::ST_RECENT:       result_next.state_code = bpd_pkg::CODE_RECENT;
      bpd_pkg::ST_REGISTERED:   result_next.state_code = bpd_pkg::CODE_REGISTERED;
      bpd_pkg::ST_TRANSITIONAL: result_next.state_code = bpd_pkg::CODE_TRANSITIONAL;
      bpd_pkg::ST_EXTENDED:     result_next.state_code = bpd_pkg::CODE_EXTENDED;
      bpd_pkg::ST_EXT_INVALID:  result_next.state_code = bpd_pkg::CODE_EXT_INVALID;
      bpd_pkg::ST_CONSUMED:     result_next.state_code = bpd_pkg::CODE_CONSUMED;
      default:                  result_next.state_code = bpd_pkg::CODE_INIT;
    endcase
    result_next.press_registered  = (stage.phase == bpd_pkg::ST_REGISTERED);
    result_next.press_extended    = (stage.phase == bpd_pkg::ST_EXTENDED);
    result_next.press_consumed    = (stage.phase == bpd_pkg::ST_CONSUMED);
    result_next.press_in_progress = !((stage.phase == bpd_pkg::ST_INIT) ||
                                      (stage.phase == bpd_pkg::ST_READY_CLEAR) ||
                                      (stage.phase == bpd_pkg::ST_UNPRESSED));
    result_next.ready_to_work     = !((stage.phase == bpd_pkg::ST_INIT) ||
                                      (stage.phase == bpd_pkg::ST_READY_CLEAR));
    result_next.clear_accepted     = stage.accepted;
    result_next.in_first_window    = stage.first_window;
    result_next.since_press_tenths = press_prod[bpd_pkg::DIV_SHIFT +: 8];
    result_next.since_clear_tenths = clear_prod[bpd_pkg::DIV_SHIFT +: 8];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && stage_valid) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  // a full first stage behind a stalled result blocks new items
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && result_valid && !result_ready) |-> !item_ready)
    else $error("item taken while both stages are full");

  // a forced clear always stamps the clear time
  assert property (@(posedge clk) disable iff (rst)
    (item_xfer && (item.mode == bpd_pkg::MODE_FORCE_CLEAR)) |=>
    (last_clear_time == $past(item.now_ms)))
    else $error("forced clear did not record its time");

  // mark consumed lands in consumed
  assert property (@(posedge clk) disable iff (rst)
    (item_xfer && (item.mode == bpd_pkg::MODE_CONSUME)) |=> (phase == bpd_pkg::ST_CONSUMED))
    else $error("mark consumed did not reach consumed");

  // the first window never reopens
  assert property (@(posedge clk) disable iff (rst)
    !first_window |=> !first_window)
    else $error("first window flag set again");

  // start-up only leaves for ready-to-clear or consumed
  assert property (@(posedge clk) disable iff (rst)
    (phase == bpd_pkg::ST_INIT) |=>
    ((phase == bpd_pkg::ST_INIT) || (phase == bpd_pkg::ST_READY_CLEAR) ||
     (phase == bpd_pkg::ST_CONSUMED)))
    else $error("illegal exit from start-up");
`endif

endmodule

@@ tb/sv/bpd_press_checker.sv @@
`timescale 1ns / 100ps
// checker for the button press duration block: watches the item, result and config channels,
// predicts each result and compares it field by field; depends on bpd_pkg
module bpd_press_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  bpd_pkg::item_t                  item,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  bpd_pkg::result_t                result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              compared
);

  // predicted block state
  logic [3:0]  phase;
  logic [31:0] press_start;
  logic [31:0] init_start;
  logic [31:0] last_clear;
  logic        init_seen;
  logic        first_window;

  // predicted configuration
  logic [15:0] min_press;
  logic [15:0] max_press;
  logic [15:0] ext_press;
  logic [15:0] init_period;
  logic [15:0] clear_period;

  bpd_pkg::result_t expected_results[$];

  // advance the predicted state by one item and build the result it causes
  function automatic bpd_pkg::result_t predict_press_step(input bpd_pkg::item_t it);
    bpd_pkg::result_t r;
    logic [31:0]      t;
    logic [31:0]      held;
    logic [31:0]      tenths;
    logic             live;
    logic             accepted;
    t        = it.now_ms;
    accepted = 1'b0;
    case (bpd_pkg::mode_t'(it.mode))
      bpd_pkg::MODE_SAMPLE: begin
        if (first_window && t > bpd_pkg::FIRST_WINDOW_MS) first_window = 1'b0;
        live = 1'b1;
        // start-up wait: first sample only starts the timer
        if (phase == bpd_pkg::CODE_INIT) begin
          if (!init_seen) begin
            init_seen  = 1'b1;
            init_start = t;
            live       = 1'b0;
          end else if (t - init_start <= {16'd0, init_period}) begin
            live = 1'b0;
          end else begin
            phase = bpd_pkg::CODE_READY_CLEAR;
          end
        end
        if (live && phase != bpd_pkg::CODE_READY_CLEAR) begin
          if (!it.pressed_raw) begin
            phase = bpd_pkg::CODE_UNPRESSED;
          end else begin
            held = t - press_start;
            case (phase)
              bpd_pkg::CODE_UNPRESSED: begin
                phase       = bpd_pkg::CODE_RECENT;
                press_start = t;
              end
              bpd_pkg::CODE_RECENT: begin
                if (held >= {16'd0, min_press}) phase = bpd_pkg::CODE_REGISTERED;
              end
              bpd_pkg::CODE_REGISTERED: begin
                if (held >= {16'd0, max_press}) phase = bpd_pkg::CODE_TRANSITIONAL;
              end
              bpd_pkg::CODE_TRANSITIONAL: begin
                if (held >= {16'd0, ext_press}) phase = bpd_pkg::CODE_EXTENDED;
              end
              bpd_pkg::CODE_EXTENDED: begin
                if (held >= {16'd0, ext_press} + bpd_pkg::EXT_INVALID_EXTRA_MS)
                  phase = bpd_pkg::CODE_EXT_INVALID;
              end
              default: ;
            endcase
          end
        end
      end
      bpd_pkg::MODE_CONSUME: phase = bpd_pkg::CODE_CONSUMED;
      default: begin
        // clear request is gated by spacing and state, forced clear never
        accepted = 1'b1;
        if (bpd_pkg::mode_t'(it.mode) == bpd_pkg::MODE_CLEAR) begin
          if (phase != bpd_pkg::CODE_READY_CLEAR && t - last_clear < {16'd0, clear_period})
            accepted = 1'b0;
          if (phase == bpd_pkg::CODE_INIT || phase > bpd_pkg::CODE_UNPRESSED) accepted = 1'b0;
        end
        if (accepted) begin
          last_clear = t;
          if (phase == bpd_pkg::CODE_READY_CLEAR) phase = bpd_pkg::CODE_UNPRESSED;
        end
      end
    endcase
    r.state_code        = phase;
    r.press_registered  = (phase == bpd_pkg::CODE_REGISTERED);
    r.press_extended    = (phase == bpd_pkg::CODE_EXTENDED);
    r.press_in_progress = (phase > bpd_pkg::CODE_UNPRESSED);
    r.press_consumed    = (phase == bpd_pkg::CODE_CONSUMED);
    r.ready_to_work     = (phase >= bpd_pkg::CODE_UNPRESSED);
    r.clear_accepted    = accepted;
    r.in_first_window   = first_window;
    tenths               = (t - press_start) / 32'd100;
    r.since_press_tenths = tenths[7:0];
    tenths               = (t - last_clear) / 32'd100;
    r.since_clear_tenths = tenths[7:0];
    return r;
  endfunction

  // result compare, then config and item transfers
  always @(posedge clk) begin
    bpd_pkg::result_t want;
    if (rst) begin
      phase        <= bpd_pkg::CODE_INIT;
      press_start  <= '0;
      init_start   <= '0;
      last_clear   <= '0;
      init_seen    <= 1'b0;
      first_window <= 1'b1;
      min_press    <= bpd_pkg::MIN_PRESS_RST;
      max_press    <= bpd_pkg::MAX_PRESS_RST;
      ext_press    <= bpd_pkg::EXT_PRESS_RST;
      init_period  <= bpd_pkg::INIT_PERIOD_RST;
      clear_period <= bpd_pkg::CLEAR_PERIOD_RST;
      expected_results.delete();
      errors   <= 0;
      pending  <= 0;
      compared <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          $error("result transfer with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          compared <= compared + 1;
          if (result !== want) errors <= errors + 1;
          if (result.state_code !== want.state_code)
            $error("state_code expected %0d got %0d", want.state_code, result.state_code);
          if (result.press_registered !== want.press_registered)
            $error("press_registered expected %0d got %0d",
                   want.press_registered, result.press_registered);
          if (result.press_extended !== want.press_extended)
            $error("press_extended expected %0d got %0d",
                   want.press_extended, result.press_extended);
          if (result.press_in_progress !== want.press_in_progress)
            $error("press_in_progress expected %0d got %0d",
                   want.press_in_progress, result.press_in_progress);
          if (result.press_consumed !== want.press_consumed)
            $error("press_consumed expected %0d got %0d",
                   want.press_consumed, result.press_consumed);
          if (result.ready_to_work !== want.ready_to_work)
            $error("ready_to_work expected %0d got %0d",
                   want.ready_to_work, result.ready_to_work);
          if (result.clear_accepted !== want.clear_accepted)
            $error("clear_accepted expected %0d got %0d",
                   want.clear_accepted, result.clear_accepted);
          if (result.in_first_window !== want.in_first_window)
            $error("in_first_window expected %0d got %0d",
                   want.in_first_window, result.in_first_window);
          if (result.since_press_tenths !== want.since_press_tenths)
            $error("since_press_tenths expected %0d got %0d",
                   want.since_press_tenths, result.since_press_tenths);
          if (result.since_clear_tenths !== want.since_clear_tenths)
            $error("since_clear_tenths expected %0d got %0d",
                   want.since_clear_tenths, result.since_clear_tenths);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (bpd_pkg::cfg_reg_t'(cfg_index))
          bpd_pkg::REG_MIN_PRESS:    min_press    = cfg_data;
          bpd_pkg::REG_MAX_PRESS:    max_press    = cfg_data;
          bpd_pkg::REG_EXT_PRESS:    ext_press    = cfg_data;
          bpd_pkg::REG_INIT_PERIOD:  init_period  = cfg_data;
          bpd_pkg::REG_CLEAR_PERIOD: clear_period = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) expected_results.push_back(predict_press_step(item));
      pending <= expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_button_press_duration_fsm_unit.sv @@
`timescale 1ns / 100ps
// top of the button press duration testbench: clock, reset, stimulus and verdict
// depends on bpd_pkg, button_press_duration_fsm_unit and bpd_press_checker
module tb_button_press_duration_fsm_unit;

  localparam int TIMEOUT_CYCLES   = 200000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int NUM_PHASES       = 8;
  localparam int PHASE_ITEMS      = 100;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            item_valid   = 1'b0;
  logic                            item_ready;
  bpd_pkg::item_t                  item         = '0;
  logic                            result_valid;
  logic                            result_ready = 1'b0;
  bpd_pkg::result_t                result;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [bpd_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [15:0]                     cfg_data     = '0;

  int errors;
  int pending;
  int compared;

  int          cycle_count  = 0;
  int          stall_pct    = 0;
  int          idle_pct     = 0;
  logic        hold_request = 1'b0;
  int          hold_count   = 0;
  int          items_sent   = 0;
  logic [31:0] now          = '0;

  // stimulus copy of the thresholds, used only to aim press lengths and clear spacing
  int cfg_min   = int'(bpd_pkg::MIN_PRESS_RST);
  int cfg_max   = int'(bpd_pkg::MAX_PRESS_RST);
  int cfg_ext   = int'(bpd_pkg::EXT_PRESS_RST);
  int cfg_clear = int'(bpd_pkg::CLEAR_PERIOD_RST);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_press_duration_fsm_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bpd_press_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .compared     (compared)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_count   <= 0;
    end else if (hold_request && hold_count < LONG_HOLD_CYCLES) begin
      result_ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item after an optional gap and hold it until the transfer
  task automatic send_item(input bpd_pkg::mode_t m, input logic [31:0] t, input logic p);
    logic taken;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    item       <= '{mode: m, now_ms: t, pressed_raw: p};
    do begin
      @(negedge clk);
      taken = item_ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register transfer; valid is lowered by the caller
  task automatic write_reg(input bpd_pkg::cfg_reg_t r, input logic [15:0] v);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic load_settings(input logic [15:0] v_min, input logic [15:0] v_max,
                               input logic [15:0] v_ext, input logic [15:0] v_init,
                               input logic [15:0] v_clear);
    write_reg(bpd_pkg::REG_MIN_PRESS, v_min);
    write_reg(bpd_pkg::REG_MAX_PRESS, v_max);
    write_reg(bpd_pkg::REG_EXT_PRESS, v_ext);
    write_reg(bpd_pkg::REG_INIT_PERIOD, v_init);
    write_reg(bpd_pkg::REG_CLEAR_PERIOD, v_clear);
    cfg_valid <= 1'b0;
    cfg_min   = int'(v_min);
    cfg_max   = int'(v_max);
    cfg_ext   = int'(v_ext);
    cfg_clear = int'(v_clear);
  endtask

  function automatic logic [15:0] pick_ms();
    if ($urandom_range(7) == 0) return 16'($urandom_range(65535));
    return 16'($urandom_range(4000));
  endfunction

  // release, press, then samples aimed at the phase thresholds and their neighbors
  task automatic press_episode();
    int          hits;
    int          thr;
    int          delta;
    logic [31:0] t0;
    logic [31:0] target;
    now += $urandom_range(1, 300);
    send_item(bpd_pkg::MODE_SAMPLE, now, 1'b0);
    now += $urandom_range(1, 300);
    t0 = now;
    send_item(bpd_pkg::MODE_SAMPLE, now, 1'b1);
    hits = $urandom_range(1, 8);
    for (int k = 0; k < hits; k++) begin
      case ($urandom_range(4))
        0:       thr = cfg_min;
        1:       thr = cfg_max;
        2:       thr = cfg_ext;
        3:       thr = cfg_ext + 2000;
        default: thr = $urandom_range(cfg_ext + 2500);
      endcase
      delta = int'($urandom_range(2)) - 1;
      if (thr + delta < 0) delta = 0;
      target = t0 + thr + delta;
      if (target - t0 > now - t0) now = target;
      else now += $urandom_range(1, 40);
      send_item(bpd_pkg::MODE_SAMPLE, now, $urandom_range(11) != 0);
      if ($urandom_range(19) == 0) send_item(bpd_pkg::MODE_CONSUME, now, 1'b1);
    end
    if ($urandom_range(3) != 0) begin
      now += $urandom_range(1, 100);
      send_item(bpd_pkg::MODE_SAMPLE, now, 1'b0);
    end
  endtask

  // one clear request, spaced near the clear period or by a random step
  task automatic clear_episode();
    int step;
    if ($urandom_range(1) == 1) begin
      now += $urandom_range(1, 50);
      send_item(bpd_pkg::MODE_SAMPLE, now, 1'b0);
    end
    if ($urandom_range(3) == 0) step = $urandom_range(3000);
    else step = cfg_clear + int'($urandom_range(2)) - 1;
    if (step < 0) step = 0;
    now += step;
    send_item(bpd_pkg::MODE_CLEAR, now, 1'($urandom_range(1)));
  endtask

  task automatic random_burst(input int goal);
    int pick;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        press_episode();
      end else if (pick < 70) begin
        now += $urandom_range(2000);
        send_item(bpd_pkg::MODE_CONSUME, now, 1'($urandom_range(1)));
      end else if (pick < 85) begin
        clear_episode();
      end else if (pick < 92) begin
        now += $urandom_range(5000);
        send_item(bpd_pkg::MODE_FORCE_CLEAR, now, 1'($urandom_range(1)));
      end else begin
        // noise: any mode at any time, sometimes a jump across the whole time range
        if ($urandom_range(1) == 1) now = $urandom();
        else now += $urandom_range(100000);
        send_item(bpd_pkg::mode_t'($urandom_range(3)), now, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : stimulus
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: start-up, clear gating, every press phase, consume, time wrap
    send_item(bpd_pkg::MODE_SAMPLE, 32'd0, 1'b0);            // starts the start-up wait
    send_item(bpd_pkg::MODE_CLEAR, 32'd5, 1'b0);             // refused during start-up
    send_item(bpd_pkg::MODE_FORCE_CLEAR, 32'd10, 1'b1);      // forced, state kept
    send_item(bpd_pkg::MODE_SAMPLE, 32'd1000, 1'b0);         // wait not yet over
    send_item(bpd_pkg::MODE_SAMPLE, 32'd1001, 1'b1);         // to ready-to-clear, button ignored
    send_item(bpd_pkg::MODE_SAMPLE, 32'd1500, 1'b1);         // ready-to-clear holds
    send_item(bpd_pkg::MODE_CLEAR, 32'd1600, 1'b0);          // releases ready-to-clear
    send_item(bpd_pkg::MODE_CLEAR, 32'd1700, 1'b0);          // too soon after last clear
    send_item(bpd_pkg::MODE_CLEAR, 32'd2600, 1'b0);          // exactly one period later
    send_item(bpd_pkg::MODE_SAMPLE, 32'd3000, 1'b1);         // press starts
    send_item(bpd_pkg::MODE_SAMPLE, 32'd3749, 1'b1);
    send_item(bpd_pkg::MODE_SAMPLE, 32'd3750, 1'b1);         // registered
    send_item(bpd_pkg::MODE_CLEAR, 32'd5000, 1'b1);          // refused while pressed
    send_item(bpd_pkg::MODE_SAMPLE, 32'd6000, 1'b1);         // transitional
    send_item(bpd_pkg::MODE_SAMPLE, 32'd8000, 1'b1);         // extended
    send_item(bpd_pkg::MODE_SAMPLE, 32'd9999, 1'b1);
    send_item(bpd_pkg::MODE_SAMPLE, 32'd10000, 1'b1);        // ext-invalid, window still open
    send_item(bpd_pkg::MODE_SAMPLE, 32'd10001, 1'b1);        // first window closes
    send_item(bpd_pkg::MODE_CONSUME, 32'd10100, 1'b1);
    send_item(bpd_pkg::MODE_SAMPLE, 32'd10200, 1'b1);        // consumed while held
    send_item(bpd_pkg::MODE_SAMPLE, 32'd10300, 1'b0);        // release
    send_item(bpd_pkg::MODE_FORCE_CLEAR, 32'hFFFF_FFFF, 1'b0);
    send_item(bpd_pkg::MODE_SAMPLE, 32'hFFFF_FFFF, 1'b1);    // press at the top of the range
    send_item(bpd_pkg::MODE_SAMPLE, 32'd800, 1'b1);          // held across the wrap
    send_item(bpd_pkg::MODE_CONSUME, 32'h8000_0000, 1'b0);
    wait_drained();
    now = 32'h8000_0000;

    // random phases: all but the first load new settings; the idle and stall mix rotates among four
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;
        1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        NUM_PHASES - 1: load_settings(bpd_pkg::MIN_PRESS_RST, bpd_pkg::MAX_PRESS_RST,
                                      bpd_pkg::EXT_PRESS_RST, bpd_pkg::INIT_PERIOD_RST,
                                      bpd_pkg::CLEAR_PERIOD_RST);
        default: load_settings(pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms());
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 76; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 76; end
        default: begin idle_pct = 32; stall_pct <= 32; end
      endcase
      if (p == 0) hold_request <= 1'b1;
      goal = items_sent + PHASE_ITEMS;
      random_burst(goal);
      wait_drained();
    end

    $display("run: %0d item transfers over %0d register settings, %0d results compared",
             items_sent, NUM_PHASES - 1, compared);
    $display("run: idle and stall mixes plus one long result hold-off");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bpd_pkg.sv
sv/button_press_duration_fsm_unit.sv
tb/sv/bpd_press_checker.sv
tb/sv/tb_button_press_duration_fsm_unit.sv
